// File: src/lsr_pkg.sv
package lsr_pkg;

    // Request operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Walk modes.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_HORIZONTAL = 2'd0;
    localparam t_mode MODE_VERTICAL   = 2'd1;
    localparam t_mode MODE_GENERAL    = 2'd2;

    // Configuration register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HALF_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_HALF_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_PIXEL_COLOR = 2'd2;

    localparam int HALF_W   = 11;
    localparam int COLOR_W  = 4;
    localparam int SCREEN_W = 13;

    localparam logic [HALF_W-1:0]  HALF_WIDTH_RST  = 11'd400;
    localparam logic [HALF_W-1:0]  HALF_HEIGHT_RST = 11'd300;
    localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST = 4'd14;

endpackage

// File: src/line_segment_rasterizer_core.sv
// Line segment rasterizer.
//
// Input channel (i_in_valid / o_in_stall): a request with operation load
// carries two endpoints in signed logical coordinates; a request with
// operation advance asks for the next pixel of the loaded segment. An
// advance while no segment is active is taken and produces nothing.
// Output channel (o_out_valid / i_out_stall): one pixel per advance, in
// screen coordinates (x + half_width, half_height - y), with the configured
// color and a flag on the final pixel of the segment.
//
// Horizontal and vertical segments load without a stall. A general segment
// needs the slope as an exact quotient and remainder from a bit-serial
// divider that retires one quotient bit per cycle, so the input stays
// stalled after a general load is taken until the divider has finished.
// Advances run at one request per cycle when nothing stalls; the pixel
// appears in the output register the cycle after the request is taken.
// While the receiver stalls, the pixel waits in the output register and
// every further request is stalled until it leaves. Reset (synchronous,
// active low) drops any segment, empties the output register and restores
// the configuration registers to 400, 300 and 14.
module line_segment_rasterizer_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic signed [COORD_BITS-1:0]         i_start_x,
    input  logic signed [COORD_BITS-1:0]         i_start_y,
    input  logic signed [COORD_BITS-1:0]         i_end_x,
    input  logic signed [COORD_BITS-1:0]         i_end_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lsr_pkg::SCREEN_W-1:0] o_screen_x,
    output logic signed [lsr_pkg::SCREEN_W-1:0] o_screen_y,
    output logic [lsr_pkg::COLOR_W-1:0]          o_color,
    output logic                                 o_last_pixel
);

    localparam int C     = COORD_BITS;
    localparam int SUM_W = COORD_BITS + lsr_pkg::SCREEN_W;

    // Configuration.
    logic [lsr_pkg::HALF_W-1:0]  r_half_width;
    logic [lsr_pkg::HALF_W-1:0]  r_half_height;
    logic [lsr_pkg::COLOR_W-1:0] r_pixel_color;

    // Control state.
    logic r_active, n_active;
    logic r_busy, n_busy;
    logic r_out_valid, n_out_valid;

    // Segment state.
    lsr_pkg::t_mode     r_mode, n_mode;
    logic signed [C-1:0] r_walk_pos, n_walk_pos;
    logic signed [C-1:0] r_walk_end, n_walk_end;
    logic signed [C-1:0] r_fixed, n_fixed;
    logic signed [C:0]   r_y_q, n_y_q;
    logic [C:0]          r_y_rem, n_y_rem;
    logic signed [C:0]   r_step_q, n_step_q;
    logic [C:0]          r_step_rem, n_step_rem;
    logic [C:0]          r_ddx, n_ddx;
    logic [C-1:0]        r_dx, n_dx;
    logic                r_dy_neg, n_dy_neg;

    // Output payload.
    logic [lsr_pkg::SCREEN_W-1:0] r_sx, n_sx;
    logic [lsr_pkg::SCREEN_W-1:0] r_sy, n_sy;
    logic [lsr_pkg::COLOR_W-1:0]  r_color, n_color;
    logic                         r_last, n_last;

    logic w_in_fire;
    logic w_load_fire;
    logic w_adv_fire;

    // Load decode: order endpoints by x and classify.
    logic                w_swap;
    logic signed [C-1:0] w_ax, w_ay, w_bx, w_by;
    logic [C:0]          w_dx_full;
    logic signed [C:0]   w_dy;
    logic [C:0]          w_dy_abs;
    logic                w_horiz, w_vert;

    // Divider.
    logic         w_div_done;
    logic [C-1:0] w_div_q;
    logic [C-1:0] w_div_r;

    // Walk and pixel arithmetic.
    logic                w_last;
    logic [C+1:0]        w_acc;
    logic                w_carry;
    logic signed [C-1:0] w_x;
    logic signed [C:0]   w_y;
    logic [SUM_W-1:0]    w_sx_full;
    logic [SUM_W-1:0]    w_sy_full;

    assign o_in_stall  = r_busy || (r_out_valid && i_out_stall);
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_load_fire = w_in_fire && (i_operation == lsr_pkg::OP_LOAD);
    assign w_adv_fire  = w_in_fire && (i_operation == lsr_pkg::OP_ADVANCE) && r_active;

    assign w_swap    = (i_start_x > i_end_x);
    assign w_ax      = w_swap ? i_end_x : i_start_x;
    assign w_ay      = w_swap ? i_end_y : i_start_y;
    assign w_bx      = w_swap ? i_start_x : i_end_x;
    assign w_by      = w_swap ? i_start_y : i_end_y;
    assign w_dx_full = (C+1)'({w_bx[C-1], w_bx} - {w_ax[C-1], w_ax});
    assign w_dy      = {w_by[C-1], w_by} - {w_ay[C-1], w_ay};
    assign w_dy_abs  = w_dy[C] ? (C+1)'(-w_dy) : (C+1)'(w_dy);
    assign w_horiz   = (w_ay == w_by);
    assign w_vert    = (w_ax == w_bx);

    // The slope dy/dx is divided as magnitudes; the sign is folded in when the
    // divider finishes so that the quotient is floored.
    lsr_div #(
        .WIDTH (C)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_load_fire && !w_horiz && !w_vert),
        .i_dividend  (w_dy_abs[C-1:0]),
        .i_divisor   (w_dx_full[C-1:0]),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    assign w_last  = (r_walk_pos >= r_walk_end);
    assign w_acc   = {1'b0, r_y_rem} + {1'b0, r_step_rem};
    assign w_carry = (w_acc >= {1'b0, r_ddx});

    always_comb begin
        w_x = r_walk_pos;
        w_y = {r_fixed[C-1], r_fixed};
        unique case (r_mode)
            lsr_pkg::MODE_VERTICAL: begin
                w_x = r_fixed;
                w_y = {r_walk_pos[C-1], r_walk_pos};
            end
            lsr_pkg::MODE_GENERAL: begin
                w_y = r_y_q;
            end
            default: begin
            end
        endcase
    end

    // Screen coordinates wrap to the output width.
    assign w_sx_full = {{(SUM_W-C){w_x[C-1]}}, w_x}
                     + {{(SUM_W-lsr_pkg::HALF_W){1'b0}}, r_half_width};
    assign w_sy_full = {{(SUM_W-lsr_pkg::HALF_W){1'b0}}, r_half_height}
                     - {{(SUM_W-C-1){w_y[C]}}, w_y};

    always_comb begin
        n_active    = r_active;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_walk_pos  = r_walk_pos;
        n_walk_end  = r_walk_end;
        n_fixed     = r_fixed;
        n_y_q       = r_y_q;
        n_y_rem     = r_y_rem;
        n_step_q    = r_step_q;
        n_step_rem  = r_step_rem;
        n_ddx       = r_ddx;
        n_dx        = r_dx;
        n_dy_neg    = r_dy_neg;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_color     = r_color;
        n_last      = r_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_load_fire) begin
            n_active = 1'b1;
            if (w_horiz) begin
                n_mode     = lsr_pkg::MODE_HORIZONTAL;
                n_walk_pos = w_ax;
                n_walk_end = w_bx;
                n_fixed    = w_ay;
            end else if (w_vert) begin
                n_mode     = lsr_pkg::MODE_VERTICAL;
                n_walk_pos = (w_ay < w_by) ? w_ay : w_by;
                n_walk_end = (w_ay < w_by) ? w_by : w_ay;
                n_fixed    = w_ax;
            end else begin
                n_mode     = lsr_pkg::MODE_GENERAL;
                n_busy     = 1'b1;
                n_walk_pos = w_ax;
                n_walk_end = w_bx;
                n_dx       = w_dx_full[C-1:0];
                n_ddx      = {w_dx_full[C-1:0], 1'b0};
                n_dy_neg   = w_dy[C];
                n_y_q      = {w_ay[C-1], w_ay};
                n_y_rem    = {1'b0, w_dx_full[C-1:0]};
            end
        end else if (w_adv_fire) begin
            n_out_valid = 1'b1;
            n_sx        = w_sx_full[lsr_pkg::SCREEN_W-1:0];
            n_sy        = w_sy_full[lsr_pkg::SCREEN_W-1:0];
            n_color     = r_pixel_color;
            n_last      = w_last;
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_walk_pos = r_walk_pos + C'(1);
                if (r_mode == lsr_pkg::MODE_GENERAL) begin
                    n_y_rem = w_carry ? (C+1)'(w_acc - {1'b0, r_ddx}) : w_acc[C:0];
                    n_y_q   = r_y_q + r_step_q + {{C{1'b0}}, w_carry};
                end
            end
        end

        // Floor the signed slope: a negative slope with a remainder takes one
        // off the quotient and turns the remainder into its complement.
        if (w_div_done) begin
            n_busy = 1'b0;
            if (r_dy_neg && (w_div_r != '0)) begin
                n_step_q   = ~{1'b0, w_div_q};
                n_step_rem = {r_dx - w_div_r, 1'b0};
            end else if (r_dy_neg) begin
                n_step_q   = -{1'b0, w_div_q};
                n_step_rem = '0;
            end else begin
                n_step_q   = {1'b0, w_div_q};
                n_step_rem = {w_div_r, 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= lsr_pkg::HALF_WIDTH_RST;
            r_half_height <= lsr_pkg::HALF_HEIGHT_RST;
            r_pixel_color <= lsr_pkg::PIXEL_COLOR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lsr_pkg::CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data;
                lsr_pkg::CFG_HALF_HEIGHT: r_half_height <= i_cfg_data;
                lsr_pkg::CFG_PIXEL_COLOR: r_pixel_color <= i_cfg_data[lsr_pkg::COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_walk_pos <= n_walk_pos;
        r_walk_end <= n_walk_end;
        r_fixed    <= n_fixed;
        r_y_q      <= n_y_q;
        r_y_rem    <= n_y_rem;
        r_step_q   <= n_step_q;
        r_step_rem <= n_step_rem;
        r_ddx      <= n_ddx;
        r_dx       <= n_dx;
        r_dy_neg   <= n_dy_neg;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_color    <= n_color;
        r_last     <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_screen_x   = r_sx;
    assign o_screen_y   = r_sy;
    assign o_color      = r_color;
    assign o_last_pixel = r_last;

    // The divider finishes only while a general load is in setup.
    a_div_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_busy && (r_mode == lsr_pkg::MODE_GENERAL))
        else $error("divider finished outside of segment setup");

    // A general load always enters setup.
    a_general_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_fire && !w_horiz && !w_vert) |=> r_busy)
        else $error("general segment loaded without setup");

    // A fresh pixel in the output register comes from an advance request.
    a_pixel_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |-> $past(w_adv_fire))
        else $error("pixel produced without an advance request");

    // The final pixel ends the segment.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv_fire && w_last) |=> !r_active && o_last_pixel)
        else $error("segment still active after its final pixel");

endmodule

// File: src/lsr_div.sv
// Restoring divider that shifts the dividend in one bit per cycle.
module lsr_div #(
    parameter int WIDTH = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dsr;

    logic [WIDTH:0]   w_shifted;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;

    // The dividend register doubles as the quotient register: its top bit moves
    // into the partial remainder while the new quotient bit enters at the bottom.
    assign w_shifted = {r_rem, r_quo[WIDTH-1]};
    assign w_diff    = w_shifted - {1'b0, r_dsr};
    assign w_ge      = (w_shifted >= {1'b0, r_dsr});
    assign n_rem     = w_ge ? w_diff[WIDTH-1:0] : w_shifted[WIDTH-1:0];
    assign n_quo     = {r_quo[WIDTH-2:0], w_ge};

    assign o_done      = r_run && (r_cnt == CNT_W'(1));
    assign o_quotient  = n_quo;
    assign o_remainder = n_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_W'(WIDTH);
        end else if (r_run) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule
